// File: src/fir_schmitt_pulse_area_defines.svh
// Assertion macros for the FIR / Schmitt trigger / pulse area block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef FIR_SCHMITT_PULSE_AREA_DEFINES_SVH
`define FIR_SCHMITT_PULSE_AREA_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fsp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fsp: next-cycle check failed");

`endif

// File: src/fsp_pkg.sv
// Shared constants, types and register codes for the FIR / Schmitt / pulse area block.
// No dependencies.
`default_nettype none
package fsp_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int NUM_TAPS     = 5;
  localparam int WEIGHT_W     = 8;
  localparam int FILT_W       = 26;
  localparam int AREA_W       = 48;
  localparam int PROD_W       = SAMPLE_WIDTH + WEIGHT_W;
  localparam int SUM_W        = PROD_W + $clog2(NUM_TAPS);
  // wide enough to hold both the raw sum and the clamp limits
  localparam int EXT_W        = (SUM_W > FILT_W + 1) ? SUM_W : FILT_W + 1;

  localparam int FILT_MAX = 20971520;
  localparam int FILT_MIN = -20971520;

  localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((FILT_W + AREA_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - FILT_W - AREA_W;

  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TAP_0 = 3'd0,
    REG_TAP_1 = 3'd1,
    REG_TAP_2 = 3'd2,
    REG_TAP_3 = 3'd3,
    REG_TAP_4 = 3'd4,
    REG_RISE  = 3'd5,
    REG_FALL  = 3'd6
  } reg_idx_e;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [WEIGHT_W-1:0]     weight_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [SUM_W-1:0]        psum_t;
  typedef logic signed [FILT_W-1:0]       filt_t;
  typedef logic signed [AREA_W-1:0]       area_t;

  localparam area_t AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
  localparam area_t AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

  localparam weight_t TAP_RESET [NUM_TAPS] = '{8'sd1, 8'sd2, 8'sd4, 8'sd2, 8'sd1};
  localparam filt_t   RISE_RESET = 26'sd12;
  localparam filt_t   FALL_RESET = 26'sd11;

  // result of the trigger/area stage
  typedef struct packed {
    logic  trig;
    logic  latched;
    area_t area;
    filt_t filt;
  } res_t;

endpackage
`default_nettype wire

// File: src/fsp_tap_cell.sv
// One FIR tap: holds a past sample, registers its weighted product and
// adds it into the running partial sum. Depends on fsp_pkg.
`default_nettype none
module fsp_tap_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire fsp_pkg::sample_t x_i,
  input  wire fsp_pkg::weight_t weight_i,
  input  wire fsp_pkg::psum_t   psum_i,
  output fsp_pkg::sample_t      x_o,
  output fsp_pkg::psum_t        psum_o
);

  fsp_pkg::sample_t sample_q;
  fsp_pkg::prod_t   prod_q;
  fsp_pkg::prod_t   prod_d;

  assign prod_d = fsp_pkg::PROD_W'(x_i) * fsp_pkg::PROD_W'(weight_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (load_i) begin
      sample_q <= x_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign x_o    = sample_q;
  assign psum_o = psum_i + fsp_pkg::SUM_W'(prod_q);

endmodule
`default_nettype wire

// File: src/fsp_area_unit.sv
// Schmitt trigger and saturating pulse-area accumulator; also the output register.
// Depends on fsp_pkg.
`default_nettype none
module fsp_area_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire fsp_pkg::filt_t filt_i,
  input  wire fsp_pkg::filt_t rise_i,
  input  wire fsp_pkg::filt_t fall_i,
  output fsp_pkg::res_t       res_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LATCHED = 2'd1,
    PH_NORMAL  = 2'd2
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   trig_q, trig_d;
  fsp_pkg::area_t         area_q, area_d;
  fsp_pkg::filt_t         filt_q;
  logic signed [fsp_pkg::AREA_W:0] sum_wide;

  assign sum_wide = (fsp_pkg::AREA_W + 1)'(area_q) + (fsp_pkg::AREA_W + 1)'(filt_i);

  always_comb begin
    trig_d  = trig_q ? !(filt_i < fall_i) : (filt_i > rise_i);
    phase_d = phase_q;
    area_d  = area_q;
    if (trig_d) begin
      if (phase_q == PH_IDLE) begin
        phase_d = PH_LATCHED;
      end
      if (sum_wide[fsp_pkg::AREA_W] != sum_wide[fsp_pkg::AREA_W-1]) begin
        area_d = sum_wide[fsp_pkg::AREA_W] ? fsp_pkg::AREA_MIN : fsp_pkg::AREA_MAX;
      end else begin
        area_d = sum_wide[fsp_pkg::AREA_W-1:0];
      end
    end else if (phase_q != PH_LATCHED) begin
      phase_d = PH_NORMAL;
      area_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      trig_q  <= 1'b0;
      area_q  <= '0;
    end else if (load_i) begin
      phase_q <= phase_d;
      trig_q  <= trig_d;
      area_q  <= area_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      filt_q <= filt_i;
    end
  end

  assign res_o.trig    = trig_q;
  assign res_o.latched = (phase_q == PH_LATCHED);
  assign res_o.area    = area_q;
  assign res_o.filt    = filt_q;

endmodule
`default_nettype wire

// File: src/fir_schmitt_pulse_area.sv
// 5-tap FIR into a Schmitt trigger and a saturating pulse-area integrator.
// Uses fsp_pkg, fsp_tap_cell, fsp_area_unit and the assertion macro header.
//
// Input stream s_axis: one signed sample per request (tdata[15:0]).
// Output stream m_axis: one result per sample; tdata holds filtered (bits
// 25:0) and the area (bits 73:26), tuser holds the trigger level.
// APB port: weights 0..4 at 0x00..0x10, rise threshold 0x14, fall threshold
// 0x18. Writes are expected only while the pipe is empty.
//
// Pipeline, three register stages:
//   1. a row of tap cells registers the five products and shifts the sample line
//   2. the partial sum walks through the cells, is clamped and registered
//   3. trigger and area update (registered feedback loop), output register
// Throughput: one sample per cycle while the receiver holds m_axis_tready high.
// Each stage moves on when the next one is empty or draining, so a stalled
// receiver only blocks the input once all three stages are full.
// Reset clears the sample line, trigger, area and pulse phase, loads the
// register defaults (weights 1,2,4,2,1, thresholds 12/11) and empties the pipe.
`include "fir_schmitt_pulse_area_defines.svh"
`default_nettype none
module fir_schmitt_pulse_area (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // sample stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [fsp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [15:0] sample
  // result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [fsp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,  // [25:0] filtered, [73:26] area
  output logic                                     m_axis_tuser,  // trigger_high
  // config
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [fsp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  // ---------------- configuration registers ----------------
  fsp_pkg::weight_t    tap_w_q [fsp_pkg::NUM_TAPS];
  fsp_pkg::filt_t      rise_q, fall_q;
  fsp_pkg::reg_idx_e   reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = fsp_pkg::reg_idx_e'(paddr[fsp_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < fsp_pkg::NUM_TAPS; k++) begin
        tap_w_q[k] <= fsp_pkg::TAP_RESET[k];
      end
      rise_q <= fsp_pkg::RISE_RESET;
      fall_q <= fsp_pkg::FALL_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        fsp_pkg::REG_TAP_0: tap_w_q[0] <= pwdata[fsp_pkg::WEIGHT_W-1:0];
        fsp_pkg::REG_TAP_1: tap_w_q[1] <= pwdata[fsp_pkg::WEIGHT_W-1:0];
        fsp_pkg::REG_TAP_2: tap_w_q[2] <= pwdata[fsp_pkg::WEIGHT_W-1:0];
        fsp_pkg::REG_TAP_3: tap_w_q[3] <= pwdata[fsp_pkg::WEIGHT_W-1:0];
        fsp_pkg::REG_TAP_4: tap_w_q[4] <= pwdata[fsp_pkg::WEIGHT_W-1:0];
        fsp_pkg::REG_RISE:  rise_q     <= pwdata[fsp_pkg::FILT_W-1:0];
        fsp_pkg::REG_FALL:  fall_q     <= pwdata[fsp_pkg::FILT_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fsp_pkg::REG_TAP_0: prdata = 32'(tap_w_q[0]);
      fsp_pkg::REG_TAP_1: prdata = 32'(tap_w_q[1]);
      fsp_pkg::REG_TAP_2: prdata = 32'(tap_w_q[2]);
      fsp_pkg::REG_TAP_3: prdata = 32'(tap_w_q[3]);
      fsp_pkg::REG_TAP_4: prdata = 32'(tap_w_q[4]);
      fsp_pkg::REG_RISE:  prdata = 32'(rise_q);
      fsp_pkg::REG_FALL:  prdata = 32'(fall_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------- stage handshake ----------------
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic load1, load2, load3;

  assign en3   = !v3_q || m_axis_tready;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign load1 = s_axis_tvalid && en1;
  assign load2 = v1_q && en2;
  assign load3 = v2_q && en3;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // ---------------- stage 1/2: row of tap cells ----------------
  // x[k] is the window value seen by tap k; the newest sample enters at the
  // right end and each cell hands its stored sample to its left neighbor.
  fsp_pkg::sample_t x    [fsp_pkg::NUM_TAPS];
  fsp_pkg::psum_t   psum [fsp_pkg::NUM_TAPS+1];

  assign x[fsp_pkg::NUM_TAPS-1] = s_axis_tdata[fsp_pkg::SAMPLE_WIDTH-1:0];
  assign psum[0] = '0;

  // oldest tap: its stored sample drops off the end of the line
  fsp_tap_cell u_cell_0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load1),
    .x_i      (x[0]),
    .weight_i (tap_w_q[0]),
    .psum_i   (psum[0]),
    .x_o      (),
    .psum_o   (psum[1])
  );

  for (genvar k = 1; k < fsp_pkg::NUM_TAPS; k++) begin : g_cell
    fsp_tap_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (load1),
      .x_i      (x[k]),
      .weight_i (tap_w_q[k]),
      .psum_i   (psum[k]),
      .x_o      (x[k-1]),
      .psum_o   (psum[k+1])
    );
  end

  // clamp the full sum to the filtered range, then register
  logic signed [fsp_pkg::EXT_W-1:0] sum_ext;
  fsp_pkg::filt_t                   filt_d, filt_q;

  assign sum_ext = fsp_pkg::EXT_W'(psum[fsp_pkg::NUM_TAPS]);

  always_comb begin
    if (sum_ext > fsp_pkg::EXT_W'(fsp_pkg::FILT_MAX)) begin
      filt_d = fsp_pkg::FILT_W'(fsp_pkg::FILT_MAX);
    end else if (sum_ext < fsp_pkg::EXT_W'(fsp_pkg::FILT_MIN)) begin
      filt_d = fsp_pkg::FILT_W'(fsp_pkg::FILT_MIN);
    end else begin
      filt_d = sum_ext[fsp_pkg::FILT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      filt_q <= filt_d;
    end
  end

  // ---------------- stage 3: trigger and area ----------------
  fsp_pkg::res_t res;

  fsp_area_unit u_area (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load3),
    .filt_i (filt_q),
    .rise_i (rise_q),
    .fall_i (fall_q),
    .res_o  (res)
  );

  assign m_axis_tdata = {{fsp_pkg::OUT_PAD_W{1'b0}}, res.area, res.filt};
  assign m_axis_tuser = res.trig;

  // ---------------- checks ----------------
  // input only blocks when every stage is full and the receiver stalls
  `FSP_ASSERT_NOW(a_ready_only_when_full, !s_axis_tready, v1_q && v2_q && v3_q && !m_axis_tready)
  // a pending stage-2 item always lands in an empty output register
  `FSP_ASSERT_NEXT(a_stage2_drains, v2_q && !v3_q, m_axis_tvalid)
  // outside a latched pulse, a low trigger means a cleared area
  `FSP_ASSERT_NOW(a_low_clears_area, m_axis_tvalid && !res.trig && !res.latched, res.area == '0)

endmodule
`default_nettype wire
